// File: rtl/core/tlpd_pkg.sv
// Shared types and constants for the three-level priority dispatcher.
package tlpd_pkg;

	localparam int TAG_W       = 16;
	localparam int PRIO_W      = 2;
	localparam int WORKER_W    = 3;
	localparam int LIMIT_W     = 8;
	localparam int LEVELS      = 3;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_WORKERS     = 8;

	localparam logic [LIMIT_W-1:0] RESET_EXPIRE_LIMIT = 8'd3;

	// priority code that is folded into the medium queue
	localparam logic [PRIO_W-1:0] PRIO_MED_ALT = 2'd3;

	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		LVL_HIGH = 2'd0,
		LVL_MED  = 2'd1,
		LVL_LOW  = 2'd2
	} level_t;

	typedef struct packed {
		logic load;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_sts_t;

endpackage

// File: rtl/core/tlpd_ifs.sv
// Request and response channel interfaces of the dispatcher.
interface tlpd_req_if import tlpd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [TAG_W-1:0]    job_tag;
	logic [PRIO_W-1:0]   priority_req;
	logic [WORKER_W-1:0] worker;

	modport source (output valid, kind, job_tag, priority_req, worker, input ready);
	modport sink (input valid, kind, job_tag, priority_req, worker, output ready);
endinterface

interface tlpd_rsp_if import tlpd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             accepted;
	logic             queue_full;
	logic             grant_valid;
	logic [TAG_W-1:0] grant_tag;
	logic [1:0]       grant_level;

	modport source (output valid, accepted, queue_full, grant_valid, grant_tag, grant_level,
		input ready);
	modport sink (input valid, accepted, queue_full, grant_valid, grant_tag, grant_level,
		output ready);
endinterface

// File: rtl/core/tlpd_ctrl.sv
// Controller state machine: takes a request, then commits it once the result slot is free.
module tlpd_ctrl import tlpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					// hold until the result register can take the outcome
					if (sts.slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_ready  = (state_q == ST_IDLE);
	assign cmd.load   = req_valid && (state_q == ST_IDLE);
	assign cmd.commit = (state_q == ST_EXEC) && sts.slot_free;

endmodule

// File: rtl/core/tlpd_datapath.sv
// Datapath: request register, three tag queues, per-worker counters and the result register.
module tlpd_datapath import tlpd_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int WORKERS     = DEF_WORKERS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	input  logic                cfg_we,
	input  logic [LIMIT_W-1:0]  cfg_data,
	input  logic                in_kind,
	input  logic [TAG_W-1:0]    in_tag,
	input  logic [PRIO_W-1:0]   in_prio,
	input  logic [WORKER_W-1:0] in_worker,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                out_accepted,
	output logic                out_full,
	output logic                out_gvalid,
	output logic [TAG_W-1:0]    out_gtag,
	output logic [1:0]          out_glevel
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int WK_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;

	// registered request
	logic                kind_q;
	logic [TAG_W-1:0]    tag_q;
	logic [PRIO_W-1:0]   prio_q;
	logic [WORKER_W-1:0] worker_q;

	logic [LIMIT_W-1:0]  limit_q;
	logic [LIMIT_W-1:0]  hi_cnt_q [WORKERS];
	logic [LIMIT_W-1:0]  md_cnt_q [WORKERS];

	logic [FILL_W-1:0]   fill [LEVELS];
	logic [TAG_W-1:0]    head_tag [LEVELS];
	logic [LEVELS-1:0]   push;
	logic [LEVELS-1:0]   pop;

	logic                out_valid_q;
	logic                accepted_q;
	logic                full_q;
	logic                gvalid_q;
	logic [TAG_W-1:0]    gtag_q;
	logic [1:0]          glevel_q;

	level_t              enq_lvl;
	level_t              g_lvl;
	logic [WK_W-1:0]     wk;
	logic                wk_ok;
	logic [LIMIT_W-1:0]  hcnt;
	logic [LIMIT_W-1:0]  mcnt;
	logic                acc_c;
	logic                full_c;
	logic                gvalid_c;
	logic                hi_inc;
	logic                md_inc;
	logic                hi_clr;
	logic                md_clr;
	logic [LEVELS-1:0]   push_c;
	logic [LEVELS-1:0]   pop_c;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= in_kind;
			tag_q    <= in_tag;
			prio_q   <= in_prio;
			worker_q <= in_worker;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= RESET_EXPIRE_LIMIT;
		else if (cfg_we)
			limit_q <= cfg_data;
	end

	// one circular queue per level; the read port follows the head every cycle
	for (genvar l = 0; l < LEVELS; l++) begin : g_queue
		logic [TAG_W-1:0]  mem [QUEUE_DEPTH];
		logic [TAG_W-1:0]  rd_q;
		logic [PTR_W-1:0]  head_q;
		logic [FILL_W-1:0] fill_q;
		logic [PTR_W:0]    tail_sum;
		logic [PTR_W-1:0]  tail;
		logic [PTR_W-1:0]  head_nxt;

		assign tail_sum = {1'b0, head_q} + (PTR_W + 1)'(fill_q);
		assign tail = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) ?
			PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
		assign head_nxt = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

		always_ff @(posedge clk) begin
			if (push_c[l])
				mem[tail] <= tag_q;
			rd_q <= mem[head_q];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				head_q <= '0;
				fill_q <= '0;
			end else if (push_c[l]) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop_c[l]) begin
				head_q <= head_nxt;
				fill_q <= fill_q - 1'b1;
			end
		end

		assign fill[l]     = fill_q;
		assign head_tag[l] = rd_q;
	end

	assign enq_lvl = (prio_q == PRIO_MED_ALT) ? LVL_MED : level_t'(prio_q);
	assign wk      = WK_W'(worker_q);
	assign wk_ok   = 32'(worker_q) < 32'(WORKERS);
	assign hcnt    = wk_ok ? hi_cnt_q[wk] : '0;
	assign mcnt    = wk_ok ? md_cnt_q[wk] : '0;

	always_comb begin
		push     = '0;
		pop      = '0;
		acc_c    = 1'b0;
		full_c   = 1'b0;
		gvalid_c = 1'b0;
		g_lvl    = LVL_HIGH;
		hi_inc   = 1'b0;
		md_inc   = 1'b0;
		hi_clr   = 1'b0;
		md_clr   = 1'b0;
		if (kind_q == KIND_ENQ) begin
			if (fill[enq_lvl] == FILL_W'(QUEUE_DEPTH)) begin
				full_c = 1'b1;
			end else begin
				push[enq_lvl] = 1'b1;
				acc_c         = 1'b1;
			end
		end else if (wk_ok) begin
			priority if (fill[LVL_HIGH] != '0 && hcnt < limit_q) begin
				pop[LVL_HIGH] = 1'b1;
				gvalid_c      = 1'b1;
				g_lvl         = LVL_HIGH;
				hi_inc        = 1'b1;
			end else if (fill[LVL_MED] != '0 && mcnt < limit_q) begin
				pop[LVL_MED] = 1'b1;
				gvalid_c     = 1'b1;
				g_lvl        = LVL_MED;
				md_inc       = 1'b1;
				hi_clr       = 1'b1;
			end else if (fill[LVL_LOW] != '0) begin
				pop[LVL_LOW] = 1'b1;
				gvalid_c     = 1'b1;
				g_lvl        = LVL_LOW;
				hi_clr       = 1'b1;
				md_clr       = 1'b1;
			end else begin
				// nothing to serve: drop both streaks
				hi_clr = 1'b1;
				md_clr = 1'b1;
			end
		end
	end

	assign push_c = push & {LEVELS{cmd.commit}};
	assign pop_c  = pop & {LEVELS{cmd.commit}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WORKERS; w++) begin
				hi_cnt_q[w] <= '0;
				md_cnt_q[w] <= '0;
			end
		end else if (cmd.commit && kind_q == KIND_DEQ && wk_ok) begin
			if (hi_inc)
				hi_cnt_q[wk] <= hcnt + 1'b1;
			else if (hi_clr)
				hi_cnt_q[wk] <= '0;
			if (md_inc)
				md_cnt_q[wk] <= mcnt + 1'b1;
			else if (md_clr)
				md_cnt_q[wk] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.commit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			accepted_q <= acc_c;
			full_q     <= full_c;
			gvalid_q   <= gvalid_c;
			gtag_q     <= gvalid_c ? head_tag[g_lvl] : '0;
			glevel_q   <= gvalid_c ? g_lvl : LVL_HIGH;
		end
	end

	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_accepted = accepted_q;
	assign out_full     = full_q;
	assign out_gvalid   = gvalid_q;
	assign out_gtag     = gtag_q;
	assign out_glevel   = glevel_q;

endmodule

// File: rtl/core/three_level_priority_dispatch.sv
// Three-level priority dispatcher top level: channels, controller and datapath.
// Each request is registered on the cycle it is taken, and the controller then commits it
// once the result slot is free - the queue write or pop, the worker counter update and the
// load of the result register all happen on that commit edge. The next request is taken
// only once the controller is back in idle, so a new request is not taken while one is still
// in flight. The queue memories present their head entry through a registered read port
// that tracks the head continuously, which is what the commit cycle reads for a grant. A
// result waits in the result register while the next request is taken; the commit of that
// next request stalls only while the previous result has not been taken.
module three_level_priority_dispatch import tlpd_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int WORKERS     = DEF_WORKERS
) (
	input  logic               clk,
	input  logic               arst_n,
	tlpd_req_if.sink           req,
	tlpd_rsp_if.source         rsp,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    ready;

	tlpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlpd_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.WORKERS     (WORKERS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_kind      (req.kind),
		.in_tag       (req.job_tag),
		.in_prio      (req.priority_req),
		.in_worker    (req.worker),
		.out_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.out_accepted (rsp.accepted),
		.out_full     (rsp.queue_full),
		.out_gvalid   (rsp.grant_valid),
		.out_gtag     (rsp.grant_tag),
		.out_glevel   (rsp.grant_level)
	);

	assign req.ready = ready;

endmodule
